/* rtl/core/address_hash_table_linear_probe_assert.svh */
// Assertion macros for the page address map.
// Depends on nothing; included by the top level.
`ifndef ADDRESS_HASH_TABLE_LINEAR_PROBE_ASSERT_SVH
`define ADDRESS_HASH_TABLE_LINEAR_PROBE_ASSERT_SVH
`ifndef SYNTHESIS
`define AHT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define AHT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define AHT_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define AHT_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/core/aht_pkg.sv */
// Package for the page address map: sizes, codes and the hash mix.
// Depends on nothing.
package aht_pkg;
  localparam int TABLE_SLOTS    = 1024;
  localparam int SLOT_W         = $clog2(TABLE_SLOTS);
  localparam int PAGE_SIZE_LOG2 = 20;
  localparam int HANDLE_WIDTH   = 16;
  localparam int CNT_W          = 10;
  localparam logic [63:0] MIX_MUL_A = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MIX_MUL_B = 64'h94d049bb133111eb;
  localparam logic [CNT_W-1:0] MAX_ENTRIES_RST = CNT_W'(716);

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_LOOKUP = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_NOTFOUND = 2'd1,
    ST_FULL     = 2'd2,
    ST_ZERO     = 2'd3
  } status_t;

  typedef struct packed {
    logic        start;
    logic [63:0] key;
  } hash_req_t;

  typedef struct packed {
    logic              done;
    logic [SLOT_W-1:0] slot;
  } hash_rsp_t;
endpackage

/* rtl/core/address_hash_table_linear_probe.sv */
// Top level of the page address map: control sequencer over key and value RAMs.
// Depends on aht_pkg, aht_ram, aht_hash and the assertion header.
//
// One operation runs at a time; busy is high from acceptance until the result
// strobe. An operation costs a key mix plus a RAM read state and a compare state
// per probed slot, then registers the result beat; a zero key or the unused kind
// skips the mix and the probe. A remove also re-mixes and re-probes every entry
// that follows the removed one in its cluster. The key RAM is cleared by a pass
// over every slot after reset, during which busy is high. The result beat is
// shown on out_* for one cycle with out_valid and cannot be stalled.
`include "address_hash_table_linear_probe_assert.svh"
module address_hash_table_linear_probe (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_kind,
  input  logic [63:0] in_address,
  input  logic [15:0] in_entry_value,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [15:0] out_value_out,
  output logic [9:0]  out_entry_count,
  input  logic        cfg_we,
  input  logic [9:0]  cfg_wdata
);
  localparam int SW = aht_pkg::SLOT_W;
  localparam int HW = aht_pkg::HANDLE_WIDTH;
  localparam int CW = aht_pkg::CNT_W;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_HASH, S_RD, S_CMP, S_RM_NX, S_RM_NXCMP,
    S_RM_HASH, S_RM_RD, S_RM_CMP, S_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic [SW-1:0] slot_r, slot_nxt, nx_r, nx_nxt, addr;
  logic [SW:0]   n_r, n_nxt;
  logic [1:0]    kind_r, kind_nxt;
  logic [63:0]   key_r, key_nxt, mk_r, mk_nxt;
  logic [HW-1:0] hval_r, hval_nxt, mv_r, mv_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt, maxe_r;
  logic [1:0]    stat_r, stat_nxt;
  logic [15:0]   vout_r, vout_nxt;
  logic          ov_r, ov_nxt;
  logic          kwe, vwe;
  logic [63:0]   kwd, krd;
  logic [HW-1:0] vwd, vrd;
  aht_pkg::hash_req_t hreq;
  aht_pkg::hash_rsp_t hrsp;
  logic [CW-1:0] lim;

  aht_ram #(.WIDTH(64), .DEPTH(aht_pkg::TABLE_SLOTS)) u_key (
    .clk(clk), .we(kwe), .addr(addr), .wdata(kwd), .rdata(krd));
  aht_ram #(.WIDTH(HW), .DEPTH(aht_pkg::TABLE_SLOTS)) u_val (
    .clk(clk), .we(vwe), .addr(addr), .wdata(vwd), .rdata(vrd));
  aht_hash u_hash (.clk(clk), .rst_n(rst_n), .req(hreq), .rsp(hrsp));

  always_comb begin
    lim = (maxe_r > CW'(aht_pkg::TABLE_SLOTS - 1)) ? CW'(aht_pkg::TABLE_SLOTS - 1) : maxe_r;
  end

  always_comb begin
    state_nxt = state_r;
    slot_nxt = slot_r;
    nx_nxt = nx_r;
    n_nxt = n_r;
    kind_nxt = kind_r;
    key_nxt = key_r;
    mk_nxt = mk_r;
    hval_nxt = hval_r;
    mv_nxt = mv_r;
    cnt_nxt = cnt_r;
    stat_nxt = stat_r;
    vout_nxt = vout_r;
    ov_nxt = 1'b0;
    kwe = 1'b0;
    vwe = 1'b0;
    kwd = 64'd0;
    vwd = '0;
    addr = slot_r;
    hreq.start = 1'b0;
    hreq.key = key_r;
    case (state_r)
      S_CLEAR: begin
        kwe = 1'b1;
        slot_nxt = slot_r + 1'b1;
        if (slot_r == SW'(aht_pkg::TABLE_SLOTS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          kind_nxt = in_kind;
          hval_nxt = in_entry_value[HW-1:0];
          vout_nxt = 16'd0;
          stat_nxt = aht_pkg::ST_NOTFOUND;
          key_nxt = in_address;
          if (in_kind == aht_pkg::KIND_LOOKUP) begin
            key_nxt = {in_address[63:aht_pkg::PAGE_SIZE_LOG2],
                       {aht_pkg::PAGE_SIZE_LOG2{1'b0}}};
          end
          if (in_kind == aht_pkg::KIND_NONE || key_nxt == 64'd0) begin
            if (in_kind == aht_pkg::KIND_INSERT) stat_nxt = aht_pkg::ST_ZERO;
            state_nxt = S_OUT;
          end else begin
            hreq.start = 1'b1;
            hreq.key = key_nxt;
            state_nxt = S_HASH;
          end
        end
      end
      S_HASH: begin
        if (hrsp.done) begin
          slot_nxt = hrsp.slot;
          n_nxt = '0;
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (krd == 64'd0) begin
          if (kind_r == aht_pkg::KIND_INSERT) begin
            if (cnt_r >= lim) begin
              stat_nxt = aht_pkg::ST_FULL;
            end else begin
              kwe = 1'b1; kwd = key_r; vwe = 1'b1; vwd = hval_r;
              cnt_nxt = cnt_r + 1'b1;
              stat_nxt = aht_pkg::ST_DONE;
            end
          end
          state_nxt = S_OUT;
        end else if (krd == key_r) begin
          stat_nxt = aht_pkg::ST_DONE;
          state_nxt = S_OUT;
          case (kind_r)
            aht_pkg::KIND_INSERT: begin vwe = 1'b1; vwd = hval_r; end
            aht_pkg::KIND_LOOKUP: vout_nxt = 16'(vrd);
            aht_pkg::KIND_REMOVE: begin
              kwe = 1'b1;
              cnt_nxt = cnt_r - 1'b1;
              nx_nxt = slot_r + 1'b1;
              n_nxt = '0;
              state_nxt = S_RM_NX;
            end
            default: state_nxt = S_OUT;
          endcase
        end else if (n_r == (SW+1)'(aht_pkg::TABLE_SLOTS - 1)) begin
          if (kind_r == aht_pkg::KIND_INSERT) stat_nxt = aht_pkg::ST_FULL;
          state_nxt = S_OUT;
        end else begin
          slot_nxt = slot_r + 1'b1;
          n_nxt = n_r + 1'b1;
          state_nxt = S_RD;
        end
      end
      S_RM_NX: begin
        addr = nx_r;
        state_nxt = S_RM_NXCMP;
      end
      S_RM_NXCMP: begin
        addr = nx_r;
        if (krd == 64'd0 || n_r == (SW+1)'(aht_pkg::TABLE_SLOTS)) begin
          state_nxt = S_OUT;
        end else begin
          mk_nxt = krd;
          mv_nxt = vrd;
          kwe = 1'b1;
          hreq.start = 1'b1;
          hreq.key = krd;
          state_nxt = S_RM_HASH;
        end
      end
      S_RM_HASH: begin
        if (hrsp.done) begin
          slot_nxt = hrsp.slot;
          state_nxt = S_RM_RD;
        end
      end
      S_RM_RD: begin
        state_nxt = S_RM_CMP;
      end
      S_RM_CMP: begin
        if (krd == 64'd0) begin
          kwe = 1'b1; kwd = mk_r; vwe = 1'b1; vwd = mv_r;
          nx_nxt = nx_r + 1'b1;
          n_nxt = n_r + 1'b1;
          state_nxt = S_RM_NX;
        end else begin
          slot_nxt = slot_r + 1'b1;
          state_nxt = S_RM_RD;
        end
      end
      S_OUT: begin
        ov_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      slot_r <= '0;
      cnt_r <= '0;
      maxe_r <= aht_pkg::MAX_ENTRIES_RST;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      slot_r <= slot_nxt;
      cnt_r <= cnt_nxt;
      ov_r <= ov_nxt;
      if (cfg_we) maxe_r <= cfg_wdata;
    end
    nx_r <= nx_nxt;
    n_r <= n_nxt;
    kind_r <= kind_nxt;
    key_r <= key_nxt;
    mk_r <= mk_nxt;
    hval_r <= hval_nxt;
    mv_r <= mv_nxt;
    stat_r <= stat_nxt;
    vout_r <= vout_nxt;
  end

  assign busy = (state_r != S_IDLE);
  assign out_valid = ov_r;
  assign out_status = stat_r;
  assign out_value_out = vout_r;
  assign out_entry_count = cnt_r;

  `AHT_ASSERT_NXT(a_cnt_step, clk, rst_n, state_r == S_IDLE, cnt_r == $past(cnt_r))
  `AHT_ASSERT_IMP(a_val_idle, clk, rst_n, out_valid, state_r == S_IDLE)
  `AHT_ASSERT_IMP(a_vout_lookup, clk, rst_n, out_valid && out_value_out != 16'd0,
                  kind_r == aht_pkg::KIND_LOOKUP)
endmodule

/* rtl/core/aht_ram.sv */
// Generic single-port RAM with registered read.
// Depends on nothing.
module aht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

/* rtl/core/aht_hash.sv */
// Multi-cycle mix of a 64-bit key to its home slot; 32x32 partial products.
// Depends on aht_pkg.
module aht_hash (
  input  logic              clk,
  input  logic              rst_n,
  input  aht_pkg::hash_req_t req,
  output aht_pkg::hash_rsp_t rsp
);
  logic [63:0] v_r, v_nxt, m_r, m_nxt, acc_r, acc_nxt;
  logic [3:0]  step_r, step_nxt;
  logic        busy_r, busy_nxt;
  logic [31:0] pa, pb;
  logic [63:0] prod_r;

  always_comb begin
    pa = 32'd0;
    pb = 32'd0;
    case (step_r)
      4'd1, 4'd5: begin pa = v_r[31:0];  pb = m_r[31:0];  end
      4'd2, 4'd6: begin pa = v_r[31:0];  pb = m_r[63:32]; end
      4'd3, 4'd7: begin pa = v_r[63:32]; pb = m_r[31:0];  end
      default: begin pa = 32'd0; pb = 32'd0; end
    endcase
  end

  always_comb begin
    v_nxt = v_r;
    m_nxt = m_r;
    acc_nxt = acc_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    case (step_r)
      4'd0: begin
        if (req.start) begin
          v_nxt = req.key ^ (req.key >> 30);
          m_nxt = aht_pkg::MIX_MUL_A;
          busy_nxt = 1'b1;
          step_nxt = 4'd1;
        end
      end
      4'd1, 4'd5: step_nxt = step_r + 4'd1;
      4'd2, 4'd6: begin
        acc_nxt = prod_r;
        step_nxt = step_r + 4'd1;
      end
      4'd3, 4'd7: begin
        acc_nxt = acc_r + {prod_r[31:0], 32'd0};
        step_nxt = step_r + 4'd1;
      end
      4'd4: begin
        v_nxt = (acc_r + {prod_r[31:0], 32'd0});
        v_nxt = v_nxt ^ (v_nxt >> 27);
        m_nxt = aht_pkg::MIX_MUL_B;
        step_nxt = 4'd5;
      end
      4'd8: begin
        v_nxt = (acc_r + {prod_r[31:0], 32'd0});
        v_nxt = v_nxt ^ (v_nxt >> 31);
        busy_nxt = 1'b0;
        step_nxt = 4'd0;
      end
      default: step_nxt = 4'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= 4'd0;
      busy_r <= 1'b0;
    end else begin
      step_r <= step_nxt;
      busy_r <= busy_nxt;
    end
    v_r <= v_nxt;
    m_r <= m_nxt;
    acc_r <= acc_nxt;
    prod_r <= 64'(pa) * 64'(pb);
  end

  assign rsp.done = busy_r && !busy_nxt;
  assign rsp.slot = v_nxt[aht_pkg::SLOT_W-1:0];
endmodule

/* tb/sv/tb.sv */
// Self-checking bench for the page address map (address_hash_table_linear_probe).
// Runs a table of directed beats, then random beats under several load limits,
// and checks every result beat against a predictor or a row's expected values; needs aht_pkg and the RTL.
`timescale 1ns / 100ps
module tb;
  import aht_pkg::*;

  typedef struct {
    status_t     st;
    logic [15:0] handle;
    logic [9:0]  count;
  } map_result_t;

  typedef struct {
    kind_t       kind;
    logic [63:0] addr;
    logic [15:0] handle;
    logic        typed;
    status_t     st;
    logic [15:0] exp_handle;
    logic [9:0]  exp_count;
  } op_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_kind = KIND_LOOKUP;
  logic [63:0] in_address = '0;
  logic [15:0] in_entry_value = '0;
  logic        out_valid;
  logic [1:0]  out_status;
  logic [15:0] out_value_out;
  logic [9:0]  out_entry_count;
  logic        cfg_we = 1'b0;
  logic [9:0]  cfg_wdata = '0;

  logic [63:0] shadow_keys [TABLE_SLOTS];
  logic [15:0] shadow_handles [TABLE_SLOTS];
  int unsigned shadow_count;
  int unsigned shadow_limit;

  map_result_t pending_results[$];
  logic [63:0] key_pool[$];
  int unsigned beats_taken = 0;
  bit          failed = 1'b0;

  logic        row_typed = 1'b0;
  map_result_t row_result;

  address_hash_table_linear_probe uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_kind(in_kind), .in_address(in_address), .in_entry_value(in_entry_value),
    .out_valid(out_valid), .out_status(out_status), .out_value_out(out_value_out),
    .out_entry_count(out_entry_count), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #1_000_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic logic [63:0] page_mix(input logic [63:0] v);
    v = v ^ (v >> 30);
    v = v * MIX_MUL_A;
    v = v ^ (v >> 27);
    v = v * MIX_MUL_B;
    v = v ^ (v >> 31);
    return v;
  endfunction

  function automatic int unsigned home_of(input logic [63:0] key);
    return page_mix(key) % TABLE_SLOTS;
  endfunction

  function automatic bit find_slot(input logic [63:0] key, output int unsigned slot,
                                   output bit hit);
    int unsigned s;
    s = home_of(key);
    hit = 1'b0;
    slot = 0;
    for (int n = 0; n < TABLE_SLOTS; n++) begin
      if (shadow_keys[s] == 64'd0) begin
        slot = s;
        return 1'b1;
      end
      if (shadow_keys[s] == key) begin
        slot = s;
        hit = 1'b1;
        return 1'b1;
      end
      s = (s + 1) % TABLE_SLOTS;
    end
    return 1'b0;
  endfunction

  function automatic map_result_t map_apply(input kind_t kind, input logic [63:0] addr,
                                            input logic [15:0] handle);
    map_result_t r;
    int unsigned s, nx, d, lim;
    bit hit, ok;
    logic [63:0] k, base;
    logic [15:0] v;
    r.st = ST_NOTFOUND;
    r.handle = '0;
    lim = (shadow_limit > TABLE_SLOTS - 1) ? TABLE_SLOTS - 1 : shadow_limit;
    case (kind)
      KIND_INSERT: begin
        if (addr == 64'd0) r.st = ST_ZERO;
        else begin
          ok = find_slot(addr, s, hit);
          if (!ok) r.st = ST_FULL;
          else if (hit) begin
            shadow_handles[s] = handle;
            r.st = ST_DONE;
          end else if (shadow_count >= lim) r.st = ST_FULL;
          else begin
            shadow_keys[s] = addr;
            shadow_handles[s] = handle;
            shadow_count++;
            r.st = ST_DONE;
          end
        end
      end
      KIND_REMOVE: begin
        if (addr != 64'd0 && find_slot(addr, s, hit) && hit) begin
          shadow_keys[s] = '0;
          shadow_handles[s] = '0;
          shadow_count--;
          nx = (s + 1) % TABLE_SLOTS;
          for (int n = 0; n < TABLE_SLOTS && shadow_keys[nx] != 64'd0; n++) begin
            k = shadow_keys[nx];
            v = shadow_handles[nx];
            shadow_keys[nx] = '0;
            shadow_handles[nx] = '0;
            d = home_of(k);
            for (int m = 0; m < TABLE_SLOTS && shadow_keys[d] != 64'd0; m++)
              d = (d + 1) % TABLE_SLOTS;
            shadow_keys[d] = k;
            shadow_handles[d] = v;
            nx = (nx + 1) % TABLE_SLOTS;
          end
          r.st = ST_DONE;
        end
      end
      KIND_LOOKUP: begin
        base = addr & ~((64'd1 << PAGE_SIZE_LOG2) - 64'd1);
        if (base != 64'd0 && find_slot(base, s, hit) && hit) begin
          r.handle = shadow_handles[s];
          r.st = ST_DONE;
        end
      end
      default: ;
    endcase
    r.count = shadow_count[9:0];
    return r;
  endfunction

  always @(posedge clk) begin
    map_result_t want, got;
    if (rst_n) begin
      if (out_valid) begin
        got.st = status_t'(out_status);
        got.handle = out_value_out;
        got.count = out_entry_count;
        if (pending_results.size() == 0) begin
          $display("%t unexpected beat: status %0d value %h count %0d", $time,
                   got.st, got.handle, got.count);
          failed = 1'b1;
        end else begin
          want = pending_results.pop_front();
          if (got.st !== want.st) begin
            $display("%t status: expected %0d actual %0d", $time, want.st, got.st);
            failed = 1'b1;
          end
          if (got.handle !== want.handle) begin
            $display("%t value_out: expected %h actual %h", $time, want.handle, got.handle);
            failed = 1'b1;
          end
          if (got.count !== want.count) begin
            $display("%t entry_count: expected %0d actual %0d", $time, want.count,
                     got.count);
            failed = 1'b1;
          end
        end
      end
      if (start && !busy) begin
        want = map_apply(kind_t'(in_kind), in_address, in_entry_value);
        pending_results.push_back(row_typed ? row_result : want);
        beats_taken <= beats_taken + 1;
      end
    end
  end

  task automatic send_op(input op_row_t row);
    int unsigned gap, target;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_kind = row.kind;
    in_address = row.addr;
    in_entry_value = row.handle;
    row_typed = row.typed;
    row_result.st = row.st;
    row_result.handle = row.exp_handle;
    row_result.count = row.exp_count;
    start = 1'b1;
    target = beats_taken + 1;
    do @(negedge clk); while (beats_taken < target);
  endtask

  task automatic drain_results();
    start = 1'b0;
    row_typed = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic write_limit(input int unsigned lim);
    drain_results();
    cfg_we = 1'b1;
    cfg_wdata = lim[9:0];
    shadow_limit = lim;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic op_row_t mk(input kind_t kind, input logic [63:0] addr,
                                 input logic [15:0] handle, input bit typed = 1'b0,
                                 input status_t st = ST_DONE, input logic [15:0] h = 0,
                                 input logic [9:0] c = 0);
    op_row_t r;
    r.kind = kind; r.addr = addr; r.handle = handle;
    r.typed = typed; r.st = st; r.exp_handle = h; r.exp_count = c;
    return r;
  endfunction

  function automatic op_row_t random_op();
    int unsigned pick;
    logic [63:0] key;
    pick = $urandom_range(0, 99);
    key = key_pool[$urandom_range(0, key_pool.size() - 1)];
    if (pick < 40) return mk(KIND_INSERT, key, 16'($urandom));
    if (pick < 60) return mk(KIND_REMOVE, key, 16'($urandom));
    if (pick < 88) return mk(KIND_LOOKUP, key | 64'($urandom_range(0, 20'hFFFFF)),
                             16'($urandom));
    key = ($urandom_range(0, 4) == 0) ? 64'd0 : {$urandom, $urandom};
    return mk(kind_t'($urandom_range(0, 3)), key, 16'($urandom));
  endfunction

  op_row_t directed_ops[] = '{
    mk(KIND_LOOKUP, 64'd0, 16'h1234, 1, ST_NOTFOUND, 0, 0),
    mk(KIND_INSERT, 64'd0, 16'hFFFF, 1, ST_ZERO, 0, 0),
    mk(KIND_REMOVE, 64'd0, 16'h0000, 1, ST_NOTFOUND, 0, 0),
    mk(KIND_NONE, 64'h100000, 16'hFFFF, 1, ST_NOTFOUND, 0, 0),
    mk(KIND_INSERT, 64'h100000, 16'hFFFF, 1, ST_DONE, 0, 1),
    mk(KIND_INSERT, 64'h100000, 16'h0001, 1, ST_DONE, 0, 1),
    mk(KIND_LOOKUP, 64'h1FFFFF, 16'h0000, 1, ST_DONE, 16'h0001, 1),
    mk(KIND_INSERT, 64'hFFFFFFFFFFF00000, 16'h0000, 1, ST_DONE, 0, 2),
    mk(KIND_LOOKUP, 64'hFFFFFFFFFFFFFFFF, 16'hAAAA, 1, ST_DONE, 0, 2),
    mk(KIND_REMOVE, 64'h200000, 16'h0000, 1, ST_NOTFOUND, 0, 2),
    mk(KIND_INSERT, 64'h12345, 16'h5A5A, 1, ST_DONE, 0, 3),
    mk(KIND_LOOKUP, 64'h12345, 16'h0000, 1, ST_NOTFOUND, 0, 3),
    mk(KIND_REMOVE, 64'h12345, 16'h0000, 1, ST_DONE, 0, 2),
    mk(KIND_REMOVE, 64'h100000, 16'h0000, 1, ST_DONE, 0, 1),
    mk(KIND_LOOKUP, 64'h100000, 16'h0000, 1, ST_NOTFOUND, 0, 1),
    mk(KIND_INSERT, 64'hABCD_0000_0030_0000, 16'h0F0F),
    mk(KIND_INSERT, 64'h5555_5555_5550_0000, 16'hF0F0),
    mk(KIND_LOOKUP, 64'h5555_5555_555F_FFFF, 16'h0000)
  };

  int unsigned phase_limits[] = '{716, 1023, 30, 1, 0, 500, 8};

  initial begin
    logic [63:0] k;
    logic [63:0] kh;
    shadow_count = 0;
    shadow_limit = MAX_ENTRIES_RST;
    foreach (shadow_keys[i]) begin
      shadow_keys[i] = '0;
      shadow_handles[i] = '0;
    end
    while (key_pool.size() < 40) begin
      k = {$urandom, $urandom} & ~64'hFFFFF;
      kh = page_mix(k);
      if (k != 64'd0 && kh[9:4] == 6'd0) key_pool.push_back(k);
    end
    while (key_pool.size() < 80) begin
      k = {$urandom, $urandom} & ~64'hFFFFF;
      if (k != 64'd0) key_pool.push_back(k);
    end
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_ops[i]) send_op(directed_ops[i]);
    write_limit(1);
    send_op(mk(KIND_INSERT, 64'h700000, 16'h0007, 1, ST_FULL, 0, 3));
    send_op(mk(KIND_INSERT, 64'hFFFFFFFFFFF00000, 16'hBEEF, 1, ST_DONE, 0, 3));
    write_limit(0);
    send_op(mk(KIND_INSERT, 64'h800000, 16'h0008, 1, ST_FULL, 0, 3));

    foreach (phase_limits[p]) begin
      write_limit(phase_limits[p]);
      repeat (228) send_op(random_op());
    end

    drain_results();
    repeat (40) @(negedge clk);
    if (!failed)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/aht_pkg.sv
rtl/core/aht_ram.sv
rtl/core/aht_hash.sv
rtl/core/address_hash_table_linear_probe.sv
tb/sv/tb.sv
